@@ design/vhf_pkg.sv @@
// ----------------------------------------------------------------------------
// vhf_pkg
// Shared types and constants of the voice-activity hangover state machine.
// ----------------------------------------------------------------------------
`default_nettype none

package vhf_pkg;

  localparam int unsigned FLAG_W  = 8;
  localparam int unsigned MS_W    = 16;
  localparam int unsigned STATE_W = 2;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [MS_W-1:0]   HOLD_ON_RST  = 16'd200;
  localparam logic [MS_W-1:0]   HOLD_OFF_RST = 16'd1000;
  localparam logic [MS_W-1:0]   MS_MAX       = '1;
  localparam logic [FLAG_W-1:0] SPEECH_FLAG  = 8'd1;

  // Kinds of input transaction.
  localparam logic ACT_TICK   = 1'b0;
  localparam logic ACT_REPORT = 1'b1;

  typedef enum logic [STATE_W-1:0] {
    ST_IDLE = 2'd0,
    ST_PRE  = 2'd1,
    ST_SPCH = 2'd2,
    ST_POST = 2'd3
  } vhf_state_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HOLD_ON  = 1'b0,
    REG_HOLD_OFF = 1'b1
  } vhf_reg_t;

  // One accepted transaction as seen by the state machine.
  typedef struct packed {
    logic step;
    logic is_report;
    logic speech;
  } vhf_step_t;

  typedef struct packed {
    logic [MS_W-1:0] hold_on;
    logic [MS_W-1:0] hold_off;
  } vhf_cfg_t;

endpackage

`default_nettype wire

@@ design/vhf_if.sv @@
// ----------------------------------------------------------------------------
// vhf_in_if / vhf_out_if
// Valid/ready channels of the hangover state machine.
// ----------------------------------------------------------------------------
`default_nettype none

interface vhf_in_if import vhf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [FLAG_W-1:0] vad_value;

  modport source (output valid, output action, output vad_value, input ready);
  modport sink   (input valid, input action, input vad_value, output ready);
endinterface

interface vhf_out_if import vhf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [STATE_W-1:0] fsm_state_out;
  logic               active;

  modport source (output valid, output fsm_state_out, output active, input ready);
  modport sink   (input valid, input fsm_state_out, input active, output ready);
endinterface

`default_nettype wire

@@ design/vhf_fsm.sv @@
// ----------------------------------------------------------------------------
// vhf_fsm
// Four-state hangover machine with a saturating millisecond counter.
// ----------------------------------------------------------------------------
`default_nettype none

module vhf_fsm import vhf_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire vhf_step_t  step,
  input  wire vhf_cfg_t   cfg,
  output vhf_state_t      state_nxt
);

  vhf_state_t      state_r;
  logic [MS_W-1:0] elapsed_r;
  logic [MS_W-1:0] elapsed_nxt;
  vhf_state_t      go_state;
  logic            go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      elapsed_r <= '0;
    end else if (step.step) begin
      state_r   <= state_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

  // Transitions are taken only on reports; ticks move the counter alone.
  always_comb begin
    go       = 1'b0;
    go_state = state_r;
    case (state_r)
      ST_IDLE: begin
        if (step.speech) begin
          go = 1'b1; go_state = ST_PRE;
        end
      end
      ST_PRE: begin
        if (!step.speech) begin
          go = 1'b1; go_state = ST_IDLE;
        end else if (elapsed_r >= cfg.hold_on) begin
          go = 1'b1; go_state = ST_SPCH;
        end
      end
      ST_SPCH: begin
        if (!step.speech) begin
          go = 1'b1; go_state = ST_POST;
        end
      end
      ST_POST: begin
        if (step.speech) begin
          go = 1'b1; go_state = ST_SPCH;
        end else if (elapsed_r >= cfg.hold_off) begin
          go = 1'b1; go_state = ST_IDLE;
        end
      end
      default: begin
        go = 1'b1; go_state = ST_IDLE;
      end
    endcase

    if (step.is_report) begin
      state_nxt   = go_state;
      elapsed_nxt = go ? '0 : elapsed_r;
    end else begin
      state_nxt   = state_r;
      elapsed_nxt = (elapsed_r == MS_MAX) ? elapsed_r : elapsed_r + 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ design/vad_hangover_fsm_top.sv @@
// ----------------------------------------------------------------------------
// vad_hangover_fsm_top
// Qualifies raw voice-activity flags with hold-on and hold-off times.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake      Contents
//   in_ch    sink       valid/ready    action, vad_value
//   out_ch   source     valid/ready    fsm_state_out, active
//   cfg_*    sink       write enable   cfg_index, cfg_wdata (16 bit)
//
// Every accepted transaction gives exactly one result, registered in the cycle after it is accepted.
// The next state is computed combinationally from the state registers and the
// incoming transaction and lands in the result register, so one transaction
// is taken per cycle while the consumer keeps out_ch.ready high.
// in_ch.ready is high whenever the result register is empty or being drained
// in the same cycle; a stalled result stalls the input for that cycle.
// Reset (rst_n low, synchronous) puts the machine in idle with a zero
// counter, empties the result register and restores the hold times.
//
`default_nettype none

module vad_hangover_fsm_top import vhf_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  vhf_in_if.sink                    in_ch,
  vhf_out_if.source                 out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [MS_W-1:0]      cfg_wdata
);

  vhf_cfg_t   cfg_r;
  vhf_step_t  step;
  vhf_state_t state_nxt;
  vhf_state_t res_state_r;
  logic       res_valid_r;
  logic       in_accept;

  // Configuration registers. Writes must arrive only while the block is idle; the block itself does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hold_on  <= HOLD_ON_RST;
      cfg_r.hold_off <= HOLD_OFF_RST;
    end else if (cfg_we) begin
      case (vhf_reg_t'(cfg_index))
        REG_HOLD_ON:  cfg_r.hold_on  <= cfg_wdata;
        REG_HOLD_OFF: cfg_r.hold_off <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The result register frees its slot in the same cycle it is drained, so
  // the input is not held back by a consumer that is ready.
  assign in_ch.ready = !res_valid_r || out_ch.ready;
  assign in_accept   = in_ch.valid && in_ch.ready;

  // A report counts as speech only when its flag is exactly one.
  assign step.step      = in_accept;
  assign step.is_report = (in_ch.action == ACT_REPORT);
  assign step.speech    = (in_ch.vad_value == SPEECH_FLAG);

  vhf_fsm u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .cfg       (cfg_r),
    .state_nxt (state_nxt)
  );

  // Result register: holds the state after the last accepted transaction
  // until the consumer takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (in_accept) begin
      res_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_state_r <= state_nxt;
    end
  end

  assign out_ch.valid         = res_valid_r;
  assign out_ch.fsm_state_out = res_state_r;
  assign out_ch.active        = (res_state_r != ST_IDLE);

endmodule

`default_nettype wire

@@ design/vhf_checker.sv @@
// ----------------------------------------------------------------------------
// vhf_checker
// Port-level checks of the hangover state machine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module vhf_checker import vhf_pkg::*; (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [STATE_W-1:0] fsm_state_out,
  input wire logic               active
);

  logic [STATE_W-1:0] last_state_r;
  logic               out_accept;
  logic               legal_step;

  assign out_accept = out_valid && out_ready;

  // State of the last delivered transaction; the machine starts in idle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_state_r <= ST_IDLE;
    end else if (out_accept) begin
      last_state_r <= fsm_state_out;
    end
  end

  // Idle never jumps to speech or post-speech, speech never returns to idle
  // or pre-speech, and post-speech never goes back to pre-speech.
  always_comb begin
    case (vhf_state_t'(last_state_r))
      ST_IDLE: legal_step = (fsm_state_out == ST_IDLE) || (fsm_state_out == ST_PRE);
      ST_PRE:  legal_step = (fsm_state_out != ST_POST);
      ST_SPCH: legal_step = (fsm_state_out == ST_SPCH) || (fsm_state_out == ST_POST);
      ST_POST: legal_step = (fsm_state_out != ST_PRE);
      default: legal_step = 1'b0;
    endcase
  end

  a_one_cycle_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted transaction did not produce a result next cycle");

  a_active_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (active == (fsm_state_out != ST_IDLE)))
    else $error("active flag disagrees with state");

  a_legal_transition: assert property (@(posedge clk) disable iff (!rst_n)
    out_accept |-> legal_step)
    else $error("illegal state transition between results");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(fsm_state_out) && $stable(active))
    else $error("stalled result changed");

endmodule

bind vad_hangover_fsm_top vhf_checker u_vhf_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .fsm_state_out (out_ch.fsm_state_out),
  .active        (out_ch.active)
);

`default_nettype wire
